// ===== design/text_console_cursor_engine_macros.svh =====
// Assertion macros shared by the text console cursor engine modules.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TCCE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition in one cycle that implies a consequence in the next cycle.
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/tcce_pkg.sv =====
// Shared constants and types of the text console cursor engine.
`default_nettype none

package tcce_pkg;

	// Character codes with a special meaning.
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_BACKSPACE = 8'h08;
	localparam logic [7:0] CH_FORMFEED  = 8'h0C;
	localparam logic [7:0] CH_SPACE     = 8'h20;
	localparam logic [7:0] CH_NONE      = 8'h00;

	// Operation codes of an input word.
	localparam logic OP_PUT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Configuration register file.
	localparam int CFG_ADDR_W = 3;
	localparam logic [5:0] NUM_ROWS_RST = 6'd32;
	localparam logic [7:0] NUM_COLS_RST = 8'd128;

	typedef enum logic {
		REG_NUM_ROWS = 1'b0,
		REG_NUM_COLS = 1'b1
	} reg_idx_t;

	// Per-word control flags handed from the cursor logic to the pipeline.
	typedef struct packed {
		logic is_read;
		logic wr_en;
		logic in_range;
		logic row_was_valid;
		logic scrolled;
	} item_flags_t;

endpackage

`default_nettype wire

// ===== design/tcce_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tcce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read; a read of the address being written returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/tcce_ctrl.sv =====
// Configuration registers, cursor state, top-row pointer and row valid bits.
`default_nettype none
`include "text_console_cursor_engine_macros.svh"

module tcce_ctrl import tcce_pkg::*; #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 128
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	// Register port
	input  logic                                           psel,
	input  logic                                           penable,
	input  logic                                           pwrite,
	input  logic [CFG_ADDR_W-1:0]                          paddr,
	input  logic [31:0]                                    pwdata,
	output logic [31:0]                                    prdata,
	// Accepted command word
	input  logic                                           acc,
	input  logic                                           opcode,
	input  logic [7:0]                                     char_code,
	input  logic [4:0]                                     read_row,
	input  logic [6:0]                                     read_col,
	// Memory request and cursor after the word
	output item_flags_t                                    flags,
	output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] phys_row,
	output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] cell_col,
	output logic [7:0]                                     wr_char,
	output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] cur_row_nx,
	output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] cur_col_nx
);

	localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int NRW = $clog2(MAX_ROWS + 1);
	localparam int NCW = $clog2(MAX_COLS + 1);

	logic [5:0]          num_rows_q;
	logic [7:0]          num_cols_q;
	logic [RW-1:0]       top_q;
	logic [RW-1:0]       cur_row_q;
	logic [CW-1:0]       cur_col_q;
	logic [MAX_ROWS-1:0] row_valid_q;

	logic                cfg_we;
	reg_idx_t            cfg_idx;
	logic [NRW-1:0]      nrows;
	logic [NCW-1:0]      ncols;

	logic [NRW-1:0]      row_c;
	logic [NRW-1:0]      new_row;
	logic [NRW-1:0]      wr_row;
	logic [NRW-1:0]      srow;
	logic [NCW-1:0]      col_c;
	logic [NCW-1:0]      col_inc;
	logic [NCW-1:0]      new_col;
	logic [NCW-1:0]      wr_col;
	logic [NRW:0]        top_inc;
	logic [NRW:0]        psum;
	logic [RW-1:0]       top_next;
	logic                scroll;
	logic                ff;
	logic                do_wr;
	logic                in_range;
	logic [MAX_ROWS-1:0] rv_next;

	// Register access decode; the port never waits.
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		case (cfg_idx)
			REG_NUM_ROWS: prdata = 32'(num_rows_q);
			REG_NUM_COLS: prdata = 32'(num_cols_q);
			default:      prdata = '0;
		endcase
	end

	// Row and column counts limited to the supported range.
	always_comb begin
		if (num_rows_q == '0) begin
			nrows = NRW'(1);
		end else if (int'(num_rows_q) > MAX_ROWS) begin
			nrows = NRW'(MAX_ROWS);
		end else begin
			nrows = NRW'(num_rows_q);
		end
		if (num_cols_q == '0) begin
			ncols = NCW'(1);
		end else if (int'(num_cols_q) > MAX_COLS) begin
			ncols = NCW'(MAX_COLS);
		end else begin
			ncols = NCW'(num_cols_q);
		end
	end

	// Cursor movement for one put word, with scrolling past the bottom row.
	always_comb begin
		row_c   = NRW'(cur_row_q);
		col_c   = NCW'(cur_col_q);
		col_inc = col_c + NCW'(1);
		new_row = row_c;
		new_col = col_c;
		wr_row  = row_c;
		wr_col  = col_c;
		wr_char = char_code;
		do_wr   = 1'b0;
		ff      = 1'b0;
		if (opcode == OP_PUT) begin
			case (char_code)
				CH_NEWLINE: begin
					new_row = row_c + NRW'(1);
					new_col = '0;
				end
				CH_BACKSPACE: begin
					if (col_c != '0) begin
						new_col = col_c - NCW'(1);
					end else if (row_c != '0) begin
						new_row = row_c - NRW'(1);
						new_col = ncols - NCW'(1);
					end
					wr_row  = new_row;
					wr_col  = new_col;
					wr_char = CH_SPACE;
					do_wr   = 1'b1;
				end
				CH_FORMFEED: begin
					ff = 1'b1;
				end
				default: begin
					do_wr = 1'b1;
					if (col_inc >= ncols) begin
						new_col = '0;
						new_row = row_c + NRW'(1);
					end else begin
						new_col = col_inc;
					end
				end
			endcase
		end
		scroll = (opcode == OP_PUT) && !ff && (new_row >= nrows);
		if (scroll) begin
			new_row = nrows - NRW'(1);
		end
		if (ff) begin
			new_row = '0;
			new_col = '0;
		end
	end

	// The top-row pointer rotates within the rows in use.
	always_comb begin
		top_inc  = (NRW + 1)'(top_q) + (NRW + 1)'(1);
		top_next = (top_inc >= (NRW + 1)'(nrows)) ? '0 : RW'(top_inc);
	end

	// Screen row to physical row; a read outside the screen uses row zero.
	always_comb begin
		in_range = (int'(read_row) < int'(nrows)) && (int'(read_col) < int'(ncols));
		if (opcode == OP_READ) begin
			srow = in_range ? NRW'(read_row) : '0;
		end else begin
			srow = wr_row;
		end
		psum = (NRW + 1)'(top_q) + (NRW + 1)'(srow);
		if (psum >= (NRW + 1)'(nrows)) begin
			psum = psum - (NRW + 1)'(nrows);
		end
		phys_row = RW'(psum);
		cell_col = (opcode == OP_READ) ? CW'(read_col) : CW'(wr_col);
	end

	// Row valid bits: a written row turns valid, the row scrolled out turns blank.
	always_comb begin
		rv_next = row_valid_q;
		if (do_wr) begin
			rv_next[phys_row] = 1'b1;
		end
		if (scroll) begin
			rv_next[top_q] = 1'b0;
		end
	end

	assign flags.is_read       = (opcode == OP_READ);
	assign flags.wr_en         = (opcode == OP_PUT) && do_wr;
	assign flags.in_range      = in_range;
	assign flags.row_was_valid = row_valid_q[phys_row];
	assign flags.scrolled      = scroll;
	assign cur_row_nx          = RW'(new_row);
	assign cur_col_nx          = CW'(new_col);

	// State update; any register write restarts the console.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q  <= NUM_ROWS_RST;
			num_cols_q  <= NUM_COLS_RST;
			row_valid_q <= '0;
			top_q       <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_NUM_ROWS: num_rows_q <= pwdata[5:0];
				REG_NUM_COLS: num_cols_q <= pwdata[7:0];
				default: ;
			endcase
			row_valid_q <= '0;
			top_q       <= '0;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
		end else if (acc && (opcode == OP_PUT)) begin
			cur_row_q <= cur_row_nx;
			cur_col_q <= cur_col_nx;
			if (ff) begin
				row_valid_q <= '0;
				top_q       <= '0;
			end else begin
				row_valid_q <= rv_next;
				if (scroll) begin
					top_q <= top_next;
				end
			end
		end
	end

	`TCCE_ASSERT(a_cur_row_on_screen, clk, arst_n, NRW'(cur_row_q) < nrows, "Cursor row lies below the screen.")
	`TCCE_ASSERT(a_top_row_on_screen, clk, arst_n, NRW'(top_q) < nrows, "Top row pointer is outside the rows in use.")
	`TCCE_ASSERT_NEXT(a_scroll_to_bottom, clk, arst_n, acc && scroll && !cfg_we, NRW'(cur_row_q) == (nrows - NRW'(1)), "Scroll did not leave the cursor on the bottom row.")

endmodule

`default_nettype wire

// ===== design/text_console_cursor_engine.sv =====
// Top level of the text console cursor engine: memories, pipeline and result register.
//
// Usage:
// Command words arrive on the cmd channel (cmd_valid, cmd_stall) and carry opcode,
// char_code, read_row and read_col. A put word moves the cursor and may write one cell;
// a read word returns one screen cell. Every word produces exactly one result word on
// the rsp channel (rsp_valid, rsp_stall) with cell_char, the cursor after the word and
// the scroll flag, in command order.
// The memories are read and stage one captures the word at the edge that accepts it;
// the result register loads from stage one when it is not blocked. Throughput is one
// word per cycle while the receiver does not stall, set by the character memory and
// the row mask memory, each with one read and one write port; the row mask is read,
// modified and written back with forwarding. When the receiver stalls, the result
// register holds its word and one more word can still be accepted; cmd_stall rises
// once both are occupied. After reset the screen is blank, 32 rows by 128 columns are
// in use, the cursor is home. Write registers num_rows (address 0) and num_cols
// (address 4) only while idle; the block does not enforce it. Each write blanks the
// screen and homes the cursor. No memory clearing pass is needed.
`default_nettype none
`include "text_console_cursor_engine_macros.svh"

module text_console_cursor_engine import tcce_pkg::*; #(
	parameter int MAX_ROWS = 32,
	parameter int MAX_COLS = 128
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// Register port
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	// Command channel
	input  logic                  cmd_valid,
	output logic                  cmd_stall,
	input  logic                  opcode,
	input  logic [7:0]            char_code,
	input  logic [4:0]            read_row,
	input  logic [6:0]            read_col,
	// Result channel
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic [7:0]            cell_char,
	output logic [4:0]            cursor_row_out,
	output logic [6:0]            cursor_col_out,
	output logic                  scrolled
);

	localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CHAR_DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW = (CHAR_DEPTH > 1) ? $clog2(CHAR_DEPTH) : 1;

	logic                acc;
	logic                s1_fire;

	item_flags_t         flags_c;
	logic [RW-1:0]       phys_row_c;
	logic [CW-1:0]       cell_col_c;
	logic [7:0]          wr_char_c;
	logic [RW-1:0]       cur_row_c;
	logic [CW-1:0]       cur_col_c;
	logic [AW-1:0]       char_addr;

	logic [7:0]          char_rdata;
	logic [MAX_COLS-1:0] mask_rdata;
	logic                mask_we;
	logic [MAX_COLS-1:0] mask_cur;
	logic [MAX_COLS-1:0] mask_base;
	logic [MAX_COLS-1:0] col_onehot;
	logic [MAX_COLS-1:0] mask_wr;
	logic                cell_hit;
	logic [7:0]          cell_s1;

	logic                s1_valid_q;
	item_flags_t         flags_s1;
	logic [RW-1:0]       row_s1;
	logic [CW-1:0]       col_s1;
	logic [RW-1:0]       cur_row_s1;
	logic [CW-1:0]       cur_col_s1;

	logic                fwd_valid_q;
	logic [RW-1:0]       fwd_row_q;
	logic [MAX_COLS-1:0] fwd_mask_q;

	logic                rsp_valid_q;
	logic [7:0]          cell_char_q;
	logic [4:0]          cursor_row_q;
	logic [6:0]          cursor_col_q;
	logic                scrolled_q;

	// Handshake: the word in stage one moves on unless the result register is blocked.
	assign pready    = 1'b1;
	assign s1_fire   = s1_valid_q && !(rsp_valid_q && rsp_stall);
	assign cmd_stall = s1_valid_q && rsp_valid_q && rsp_stall;
	assign acc       = cmd_valid && !cmd_stall;

	tcce_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.acc        (acc),
		.opcode     (opcode),
		.char_code  (char_code),
		.read_row   (read_row),
		.read_col   (read_col),
		.flags      (flags_c),
		.phys_row   (phys_row_c),
		.cell_col   (cell_col_c),
		.wr_char    (wr_char_c),
		.cur_row_nx (cur_row_c),
		.cur_col_nx (cur_col_c)
	);

	// Physical rows are laid out one after another in the character memory.
	assign char_addr = AW'(phys_row_c) * AW'(MAX_COLS) + AW'(cell_col_c);

	tcce_ram #(
		.WIDTH (8),
		.DEPTH (CHAR_DEPTH)
	) u_char_ram (
		.clk   (clk),
		.we    (acc && flags_c.wr_en),
		.waddr (char_addr),
		.wdata (wr_char_c),
		.re    (acc && flags_c.is_read),
		.raddr (char_addr),
		.rdata (char_rdata)
	);

	// One mask bit per cell marks cells written since the row last turned valid.
	tcce_ram #(
		.WIDTH (MAX_COLS),
		.DEPTH (MAX_ROWS)
	) u_mask_ram (
		.clk   (clk),
		.we    (mask_we),
		.waddr (row_s1),
		.wdata (mask_wr),
		.re    (acc),
		.raddr (phys_row_c),
		.rdata (mask_rdata)
	);

	// Stage one: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_fire) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Stage one: word payload, captured with the memory reads.
	always_ff @(posedge clk) begin
		if (acc) begin
			flags_s1   <= flags_c;
			row_s1     <= phys_row_c;
			col_s1     <= cell_col_c;
			cur_row_s1 <= cur_row_c;
			cur_col_s1 <= cur_col_c;
		end
	end

	// Row mask read-modify-write; the last written mask is forwarded over the memory.
	always_comb begin
		mask_cur = (fwd_valid_q && (fwd_row_q == row_s1)) ? fwd_mask_q : mask_rdata;
		mask_base = flags_s1.row_was_valid ? mask_cur : '0;
		col_onehot = '0;
		col_onehot[col_s1] = 1'b1;
		mask_wr = mask_base | col_onehot;
		mask_we = s1_fire && flags_s1.wr_en;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (mask_we) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mask_we) begin
			fwd_row_q  <= row_s1;
			fwd_mask_q <= mask_wr;
		end
	end

	// Cell value: zero for a put; blank rows, unwritten and off-screen cells read as spaces.
	always_comb begin
		cell_hit = flags_s1.in_range && flags_s1.row_was_valid && mask_cur[col_s1];
		if (!flags_s1.is_read) begin
			cell_s1 = CH_NONE;
		end else if (cell_hit) begin
			cell_s1 = char_rdata;
		end else begin
			cell_s1 = CH_SPACE;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (s1_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			cell_char_q  <= cell_s1;
			cursor_row_q <= 5'(cur_row_s1);
			cursor_col_q <= 7'(cur_col_s1);
			scrolled_q   <= flags_s1.scrolled;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign cell_char      = cell_char_q;
	assign cursor_row_out = cursor_row_q;
	assign cursor_col_out = cursor_col_q;
	assign scrolled       = scrolled_q;

	`TCCE_ASSERT_NEXT(a_blocked_word_kept, clk, arst_n, s1_valid_q && rsp_valid_q && rsp_stall, s1_valid_q, "Word in stage one was lost while the result register was blocked.")
	`TCCE_ASSERT_NEXT(a_mask_forwarded, clk, arst_n, mask_we, fwd_valid_q && fwd_mask_q[$past(col_s1)], "Written cell is missing from the forwarded row mask.")
	`TCCE_ASSERT(a_read_never_writes, clk, arst_n, !(s1_valid_q && flags_s1.is_read && flags_s1.wr_en), "Read word carries a write request.")

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Self-checking testbench for the text console cursor engine: directed and random words.
`default_nettype none

module tb import tcce_pkg::*; ();

	localparam int ROWS_MAX = 32;
	localparam int COLS_MAX = 128;
	localparam int IDLE_PCT = 29;
	localparam int HOLD_CYCLES = 80;
	localparam int QUIET_LIMIT = 2000;

	typedef struct packed {
		logic       op;
		logic [7:0] ch;
		logic [4:0] row;
		logic [6:0] col;
	} cmd_word_t;

	typedef struct packed {
		logic [7:0] glyph;
		logic [4:0] row;
		logic [6:0] col;
		logic       scroll;
	} cursor_report_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [31:0]           pwdata;
	logic [31:0]           prdata;
	logic                  pready;
	logic                  cmd_valid;
	logic                  cmd_stall;
	logic                  opcode;
	logic [7:0]            char_code;
	logic [4:0]            read_row;
	logic [6:0]            read_col;
	logic                  rsp_valid;
	logic                  rsp_stall = 1'b0;
	logic [7:0]            cell_char;
	logic [4:0]            cursor_row_out;
	logic [6:0]            cursor_col_out;
	logic                  scrolled;

	text_console_cursor_engine #(
		.MAX_ROWS(ROWS_MAX),
		.MAX_COLS(COLS_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.opcode(opcode),
		.char_code(char_code),
		.read_row(read_row),
		.read_col(read_col),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.cell_char(cell_char),
		.cursor_row_out(cursor_row_out),
		.cursor_col_out(cursor_col_out),
		.scrolled(scrolled)
	);

	// Mirror of the console: character store, live rows, rotation and cursor.
	logic [7:0]  glyphs [0:ROWS_MAX*COLS_MAX-1];
	bit          line_live [0:ROWS_MAX-1];
	int unsigned top_line;
	int unsigned caret_line;
	int unsigned caret_col;
	int unsigned rows_cfg;
	int unsigned cols_cfg;

	cursor_report_t cursor_reports[$];
	int             fails = 0;
	int             idle_pct = IDLE_PCT;
	bit             hold_req = 1'b0;
	int             hold_left = 0;
	int             quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Register values outside the legal range are clamped.
	function automatic int unsigned rows_in_use();
		if (rows_cfg == 0) return 1;
		if (rows_cfg > ROWS_MAX) return ROWS_MAX;
		return rows_cfg;
	endfunction

	function automatic int unsigned cols_in_use();
		if (cols_cfg == 0) return 1;
		if (cols_cfg > COLS_MAX) return COLS_MAX;
		return cols_cfg;
	endfunction

	// Screen row to physical row through the rotating top pointer.
	function automatic int unsigned phys_line(input int unsigned srow);
		int unsigned p;
		p = top_line + srow;
		if (p >= rows_in_use()) p -= rows_in_use();
		return p % ROWS_MAX;
	endfunction

	function automatic void clear_console();
		int i;
		for (i = 0; i < ROWS_MAX; i++) line_live[i] = 1'b0;
		top_line = 0;
		caret_line = 0;
		caret_col = 0;
	endfunction

	// A row that is not live is filled with spaces before its first write.
	function automatic void store_glyph(input int unsigned srow, input int unsigned col,
			input logic [7:0] ch);
		int unsigned p;
		int i;
		p = phys_line(srow);
		if (!line_live[p]) begin
			for (i = 0; i < COLS_MAX; i++) glyphs[p*COLS_MAX + i] = CH_SPACE;
			line_live[p] = 1'b1;
		end
		glyphs[p*COLS_MAX + (col % COLS_MAX)] = ch;
	endfunction

	function automatic logic [7:0] fetch_glyph(input int unsigned srow, input int unsigned col);
		int unsigned p;
		if (srow >= rows_in_use() || col >= cols_in_use()) return CH_SPACE;
		p = phys_line(srow);
		if (!line_live[p]) return CH_SPACE;
		return glyphs[p*COLS_MAX + col];
	endfunction

	// Applies one word to the mirror and returns the report the block must give.
	function automatic cursor_report_t advance_console(input cmd_word_t w);
		cursor_report_t r;
		int unsigned nr;
		int unsigned nc;
		nr = rows_in_use();
		nc = cols_in_use();
		r = '0;
		if (w.op == OP_READ) begin
			r.glyph = fetch_glyph(w.row, w.col);
		end else begin
			case (w.ch)
				CH_NEWLINE: begin
					caret_line++;
					caret_col = 0;
				end
				CH_BACKSPACE: begin
					if (caret_col > 0) begin
						caret_col--;
					end else if (caret_line > 0) begin
						caret_line--;
						caret_col = nc - 1;
					end
					store_glyph(caret_line, caret_col, CH_SPACE);
				end
				CH_FORMFEED: clear_console();
				default: begin
					store_glyph(caret_line, caret_col, w.ch);
					caret_col++;
					if (caret_col >= nc) begin
						caret_col = 0;
						caret_line++;
					end
				end
			endcase
			// Running off the bottom recycles the old top row as a blank bottom row.
			if (caret_line >= nr) begin
				line_live[top_line % ROWS_MAX] = 1'b0;
				top_line++;
				if (top_line >= nr) top_line = 0;
				caret_line = nr - 1;
				r.scroll = 1'b1;
			end
		end
		r.row = 5'(caret_line);
		r.col = 7'(caret_col);
		return r;
	endfunction

	// Mostly text with line control and reads inside the screen; the rest is noise.
	function automatic cmd_word_t random_word();
		cmd_word_t w;
		int unsigned pick;
		w.op = OP_PUT;
		w.ch = 8'($urandom);
		w.row = 5'($urandom);
		w.col = 7'($urandom);
		pick = $urandom_range(99);
		if (pick < 30) begin
			w.op = OP_READ;
			if ($urandom_range(9) < 8) begin
				w.row = 5'($urandom_range(rows_in_use() - 1));
				w.col = 7'($urandom_range(cols_in_use() - 1));
			end
		end else if (pick < 38) begin
			w.ch = CH_NEWLINE;
		end else if (pick < 44) begin
			w.ch = CH_BACKSPACE;
		end else if (pick < 46) begin
			w.ch = CH_FORMFEED;
		end else if (pick < 75) begin
			w.ch = 8'($urandom_range(8'h7E, 8'h20));
		end
		return w;
	endfunction

	// Offers one word with random gaps and records its report once it is taken.
	task automatic send_word(input cmd_word_t w);
		while ($urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		opcode <= w.op;
		char_code <= w.ch;
		read_row <= w.row;
		read_col <= w.col;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		cursor_reports.push_back(advance_console(w));
	endtask

	task automatic put_byte(input logic [7:0] ch);
		cmd_word_t w;
		w.op = OP_PUT;
		w.ch = ch;
		w.row = 5'($urandom);
		w.col = 7'($urandom);
		send_word(w);
	endtask

	task automatic read_at(input logic [4:0] row, input logic [6:0] col);
		cmd_word_t w;
		w.op = OP_READ;
		w.ch = 8'($urandom);
		w.row = row;
		w.col = col;
		send_word(w);
	endtask

	task automatic send_random(input int count);
		int i;
		for (i = 0; i < count; i++) send_word(random_word());
	endtask

	// The sender stops until every outstanding report has arrived.
	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (cursor_reports.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register write with setup and access phases; upper data bits carry noise.
	task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
		logic [31:0] wd;
		wd = $urandom();
		if (idx == REG_NUM_ROWS) wd[5:0] = val[5:0];
		else wd[7:0] = val;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CFG_ADDR_W'(4 * idx);
		pwdata <= wd;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == REG_NUM_ROWS) rows_cfg = wd[5:0];
		else cols_cfg = wd[7:0];
		clear_console();
		@(posedge clk);
	endtask

	task automatic set_geometry(input logic [7:0] rows, input logic [7:0] cols);
		drain_results();
		write_reg(REG_NUM_ROWS, rows);
		write_reg(REG_NUM_COLS, cols);
	endtask

	// Reads of the blank screen right after reset, at both corners.
	task automatic test_reset_view();
		read_at(5'd0, 7'd0);
		read_at(5'd31, 7'd127);
	endtask

	// Byte zero and all-ones are stored; newline, backspace wrap and form feed.
	task automatic test_control_bytes();
		put_byte(8'h41);
		put_byte(8'h00);
		put_byte(8'hFF);
		read_at(5'd0, 7'd1);
		put_byte(CH_NEWLINE);
		put_byte(CH_BACKSPACE);
		put_byte(CH_FORMFEED);
		put_byte(CH_BACKSPACE);
		read_at(5'd0, 7'd0);
	endtask

	// Tiny screen: horizontal wrap, scroll, blank new bottom row, reads off the screen.
	task automatic test_scroll_and_bounds();
		set_geometry(8'd2, 8'd3);
		put_byte(8'h78);
		put_byte(8'h79);
		put_byte(8'h7A);
		put_byte(CH_NEWLINE);
		put_byte(8'h71);
		read_at(5'd0, 7'd0);
		read_at(5'd1, 7'd1);
		read_at(5'd2, 7'd0);
		read_at(5'd0, 7'd3);
		read_at(5'd31, 7'd127);
	endtask

	// One-cell screens, with the counts written as one and as zero.
	task automatic test_one_cell_screen();
		set_geometry(8'd1, 8'd1);
		send_random(40);
		set_geometry(8'd0, 8'd0);
		send_random(30);
	endtask

	// Back-to-back words with neither side idling.
	task automatic test_fast_stream();
		set_geometry(8'd4, 8'd8);
		idle_pct = 0;
		send_random(120);
		idle_pct = IDLE_PCT;
	endtask

	// Counts above the maximum clamp; the receiver then holds off and the block backs up.
	task automatic test_full_screen_backpressure();
		set_geometry(8'd63, 8'd255);
		send_random(30);
		hold_req = 1'b1;
		send_random(50);
	endtask

	// The sender pauses in the middle until every report is back.
	task automatic test_sender_pause();
		set_geometry(8'd3, 8'd5);
		send_random(50);
		drain_results();
		send_random(50);
	endtask

	task automatic test_odd_limits();
		set_geometry(8'd33, 8'd129);
		send_random(40);
	endtask

	task automatic test_random_geometry();
		int i;
		for (i = 0; i < 2; i++) begin
			set_geometry(8'($urandom_range(8, 1)), 8'($urandom_range(20, 1)));
			send_random(70);
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		cmd_valid <= 1'b0;
		opcode <= OP_PUT;
		char_code <= CH_NONE;
		read_row <= '0;
		read_col <= '0;
		rows_cfg = NUM_ROWS_RST;
		cols_cfg = NUM_COLS_RST;
		for (int i = 0; i < ROWS_MAX*COLS_MAX; i++) glyphs[i] = CH_NONE;
		clear_console();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_view();
		test_control_bytes();
		test_scroll_and_bounds();
		test_one_cell_screen();
		test_fast_stream();
		test_full_screen_backpressure();
		test_sender_pause();
		test_odd_limits();
		test_random_geometry();

		drain_results();
		repeat (6) @(posedge clk);
		if (fails == 0) begin
			$display("text_console_cursor_engine: match");
		end else begin
			$display("text_console_cursor_engine: mismatch");
		end
		$finish;
	end

	// Result side: compare each accepted word, then pick the next stall value.
	always @(posedge clk) begin
		cursor_report_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (cursor_reports.size() == 0) begin
				$error("result word arrived with no report outstanding");
				fails++;
			end else begin
				want = cursor_reports.pop_front();
				if (cell_char !== want.glyph) begin
					$error("cell_char expected %02h actual %02h", want.glyph, cell_char);
					fails++;
				end
				if (cursor_row_out !== want.row) begin
					$error("cursor_row_out expected %0d actual %0d", want.row, cursor_row_out);
					fails++;
				end
				if (cursor_col_out !== want.col) begin
					$error("cursor_col_out expected %0d actual %0d", want.col, cursor_col_out);
					fails++;
				end
				if (scrolled !== want.scroll) begin
					$error("scrolled expected %0b actual %0b", want.scroll, scrolled);
					fails++;
				end
			end
		end
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < idle_pct);
		end
	end

	// Ends the run when neither channel has moved a word for too long.
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("text_console_cursor_engine: mismatch");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

`default_nettype wire
